// ===== design/mshc_pkg.sv =====
// shared types and constants of the mash step heater controller
package mshc_pkg;

    localparam int MAX_STEPS = 16;
    localparam int STEP_AW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    localparam logic [3:0]  MAX_LEVEL    = 4'd11;
    localparam logic [19:0] DEFAULT_IVAL = 20'd5000;

    // seconds = (ms * SEC_DIV_MAGIC) >> SEC_DIV_SHIFT, exact for any 32-bit ms
    localparam logic [31:0] SEC_DIV_MAGIC = 32'h10624DD3;
    localparam int          SEC_DIV_SHIFT = 38;
    localparam int          SEC_W         = 23;

    // register indexes of the write port
    localparam logic [2:0] REG_STEP_COUNT    = 3'd0;
    localparam logic [2:0] REG_HYST_BELOW    = 3'd1;
    localparam logic [2:0] REG_HYST_ABOVE    = 3'd2;
    localparam logic [2:0] REG_HEAT_DWELL_MS = 3'd3;
    localparam logic [2:0] REG_HOLD_DWELL_MS = 3'd4;
    localparam logic [2:0] REG_TICK_IVAL_MS  = 3'd5;

    // ctrl_mode codes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_HEAT = 3'd1;
    localparam logic [2:0] MODE_HOLD = 3'd2;
    localparam logic [2:0] MODE_DONE = 3'd3;
    localparam logic [2:0] MODE_MAN  = 3'd4;

    typedef struct packed {
        logic [4:0]  step_count;
        logic [9:0]  hyst_below;
        logic [9:0]  hyst_above;
        logic [19:0] heat_dwell_ms;
        logic [19:0] hold_dwell_ms;
        logic [19:0] tick_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [31:0]        now_ms;
        logic [SEC_W-1:0]   now_s;
        logic               run_enable;
        logic               manual_on;
        logic [3:0]         manual_level;
    } tick_t;

    typedef struct packed {
        logic [13:0] target;
        logic [9:0]  minutes;
    } step_t;

    typedef struct packed {
        logic       en;
        logic [3:0] slot;
        step_t      entry;
    } tbl_wr_t;

    typedef struct packed {
        logic        report_valid;
        logic        stop_request;
        logic [4:0]  step_number;
        logic [15:0] seconds_left;
        logic [13:0] target_now;
        logic [2:0]  ctrl_mode;
        logic        stage_changed;
        logic [3:0]  heater_stage;
    } result_t;

endpackage

// ===== design/mshc_step_table.sv =====
// schedule step table: targets and hold minutes, one write and one read port
module mshc_step_table (
    input  logic                    aclk,
    input  mshc_pkg::tbl_wr_t       wr,
    input  logic [4:0]              rd_idx,
    output mshc_pkg::step_t         rd_entry
);

    mshc_pkg::step_t mem [mshc_pkg::MAX_STEPS];

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = 32'(wr.slot) < mshc_pkg::MAX_STEPS;
    assign rd_in_range = 32'(rd_idx) < mshc_pkg::MAX_STEPS;

    always_ff @(posedge aclk) begin
        if (wr.en && wr_in_range) begin
            mem[mshc_pkg::STEP_AW'(wr.slot)] <= wr.entry;
        end
    end

    // steps past the table read as zero target and zero hold
    assign rd_entry = rd_in_range ? mem[mshc_pkg::STEP_AW'(rd_idx)] : '0;

endmodule

// ===== design/mshc_ctrl.sv =====
// control state machine: mode, step index, hold timer, dwell and stage choice
module mshc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mshc_pkg::cfg_t        cfg,
    input  mshc_pkg::tick_t       tick,
    input  logic                  fire,
    output logic [4:0]            rd_idx,
    input  mshc_pkg::step_t       rd_entry,
    output mshc_pkg::result_t     result
);

    typedef enum logic [2:0] {
        S_IDLE = mshc_pkg::MODE_IDLE,
        S_HEAT = mshc_pkg::MODE_HEAT,
        S_HOLD = mshc_pkg::MODE_HOLD,
        S_DONE = mshc_pkg::MODE_DONE,
        S_MAN  = mshc_pkg::MODE_MAN
    } state_t;

    state_t                       state_reg, state_next;
    logic [4:0]                   idx_reg, idx_next;
    logic [mshc_pkg::SEC_W-1:0]   hs_reg, hs_next;
    logic [3:0]                   lvl_reg, lvl_next;
    logic [31:0]                  lc_reg, lc_next;
    logic signed [15:0]           pt_reg, pt_next;

    logic [4:0]          count;
    logic [19:0]         ival;
    logic signed [16:0]  delta;
    logic signed [27:0]  d28, d100, d200, d1000, ival28;
    logic signed [17:0]  temp18, tgt18, lo18, hi18, diff18;
    logic [31:0]         elapsed;
    logic [15:0]         need;
    logic                man_req;
    logic [15:0]         secs;
    logic                stop, report;
    logic [3:0]          lvl_sel;

    assign count = (32'(cfg.step_count) > mshc_pkg::MAX_STEPS) ?
                   5'(mshc_pkg::MAX_STEPS) : cfg.step_count;
    assign ival  = (cfg.tick_interval_ms == '0) ? mshc_pkg::DEFAULT_IVAL
                                                : cfg.tick_interval_ms;
    assign man_req = tick.manual_on && (tick.manual_level <= mshc_pkg::MAX_LEVEL);

    // idle or manual can only start the schedule at step zero
    assign rd_idx = (state_reg == S_IDLE || state_reg == S_MAN) ? 5'd0 : idx_reg;

    // slope terms, compared exactly against the control interval
    assign delta  = (pt_reg > 16'sd0) ?
                    ($signed({tick.temperature[15], tick.temperature}) -
                     $signed({pt_reg[15], pt_reg})) : 17'sd0;
    assign d28    = 28'(delta);
    assign d100   = d28 * 28'sd100;
    assign d200   = d28 * 28'sd200;
    assign d1000  = d28 * 28'sd1000;
    assign ival28 = $signed({8'b0, ival});

    assign temp18 = $signed({{2{tick.temperature[15]}}, tick.temperature});
    assign tgt18  = $signed({4'b0, rd_entry.target});
    assign lo18   = tgt18 - $signed({8'b0, cfg.hyst_below});
    assign hi18   = tgt18 + $signed({8'b0, cfg.hyst_above});
    assign diff18 = tgt18 - temp18;

    assign elapsed = 32'(tick.now_s) - 32'(hs_reg);
    assign need    = {rd_entry.minutes, 6'b0} - {4'b0, rd_entry.minutes, 2'b0};

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hs_next    = hs_reg;
        lvl_next   = lvl_reg;
        lc_next    = lc_reg;
        pt_next    = pt_reg;
        secs       = '0;
        stop       = 1'b0;
        report     = 1'b1;
        lvl_sel    = lvl_reg;

        if (man_req) begin
            if (state_reg != S_MAN) begin
                state_next = S_MAN;
                stop       = 1'b1;
            end
            lvl_next = tick.manual_level;
        end else begin
            if (state_reg == S_MAN) begin
                lvl_next   = 4'd0;
                state_next = S_IDLE;
            end
            if (!tick.run_enable) begin
                if (state_next != S_IDLE) begin
                    lvl_next   = 4'd0;
                    state_next = S_IDLE;
                end
            end else if (count == 5'd0) begin
                stop   = 1'b1;
                report = 1'b0;
            end else if (tick.temperature < 16'sd0) begin
                lvl_next = 4'd0;
                report   = 1'b0;
            end else begin
                if (state_next == S_IDLE) begin
                    state_next = S_HEAT;
                    idx_next   = 5'd0;
                    lc_next    = '0;
                end
                pt_next = tick.temperature;
                lvl_sel = lvl_next;
                unique case (state_next)
                    S_HEAT: begin
                        if (temp18 >= lo18) begin
                            state_next = S_HOLD;
                            hs_next    = tick.now_s;
                            lvl_sel    = 4'd3;
                        end else if ((tick.now_ms - lc_next) >= {12'b0, cfg.heat_dwell_ms}) begin
                            if (diff18 > 18'sd300)      lvl_sel = 4'd11;
                            else if (diff18 > 18'sd200) lvl_sel = 4'd6;
                            else if (diff18 > 18'sd100) lvl_sel = 4'd3;
                            else if (diff18 > 18'sd50)  lvl_sel = (d100 > ival28) ? 4'd3 : 4'd4;
                            else                        lvl_sel = (d200 > ival28) ? 4'd0 : 4'd1;
                        end
                    end
                    S_HOLD: begin
                        if (elapsed >= {16'b0, need}) begin
                            idx_next = idx_reg + 5'd1;
                            if (idx_next >= count) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_HEAT;
                                lc_next    = '0;
                            end
                        end else begin
                            secs = need - elapsed[15:0];
                            if ((tick.now_ms - lc_next) >= {12'b0, cfg.hold_dwell_ms}) begin
                                if (temp18 < lo18)          lvl_sel = 4'd3;
                                else if (temp18 > hi18)     lvl_sel = 4'd0;
                                else if (d1000 < -ival28)   lvl_sel = 4'd2;
                                else if (d1000 > ival28)    lvl_sel = 4'd0;
                                else                        lvl_sel = 4'd1;
                            end
                        end
                    end
                    S_DONE: begin
                        lvl_sel    = 4'd0;
                        stop       = 1'b1;
                        state_next = S_IDLE;
                    end
                    default: begin
                    end
                endcase
                if (lvl_sel != lvl_next) begin
                    lvl_next = lvl_sel;
                    lc_next  = tick.now_ms;
                end
            end
        end
    end

    always_comb begin
        result.heater_stage  = lvl_next;
        result.stage_changed = lvl_next != lvl_reg;
        result.ctrl_mode     = 3'(state_next);
        result.target_now    = (state_next == S_HEAT || state_next == S_HOLD ||
                                state_next == S_DONE) ? rd_entry.target : 14'd0;
        result.seconds_left  = secs;
        result.step_number   = idx_next;
        result.stop_request  = stop;
        result.report_valid  = report;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            hs_reg    <= '0;
            lvl_reg   <= '0;
            lc_reg    <= '0;
            pt_reg    <= -16'sd100;
        end else if (fire) begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hs_reg    <= hs_next;
            lvl_reg   <= lvl_next;
            lc_reg    <= lc_next;
            pt_reg    <= pt_next;
        end
    end

endmodule

// ===== design/mash_step_heater_controller_top.sv =====
// top level: stream ports, register file, input and result registers
//
// One transaction on the slave side is one controller tick (tuser 0) or one
// schedule write (tuser 1). A tick yields exactly one result transaction on
// the master side, offered from the result register; a schedule write yields
// none and is visible to the very next tick. The block takes one transaction
// per cycle for as long as the master side drains: the whole control
// decision (state, dwell, hysteresis, slope compare) is combinational
// between the input and result registers, and the millisecond-to-second
// conversion is a reciprocal multiply on the way into the input register.
// There is no clearing pass after reset; schedule steps must be written
// before the schedule runs over them. The user must write registers only
// while no transaction is in flight; the block does not enforce this.
module mash_step_heater_controller_top (
    input  logic        aclk,
    input  logic        aresetn,

    // register write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_wdata,

    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // temperature[15:0] now_ms[47:16] run_enable[48] manual_on[49]
    // manual_level[53:50] slot[57:54] slot_temp[71:58] slot_minutes[81:72]
    input  logic [87:0] s_tdata,
    // mode
    input  logic        s_tuser,

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // heater_stage[3:0] stage_changed[4] ctrl_mode[7:5] target_now[21:8]
    // seconds_left[37:22] step_number[42:38] stop_request[43] report_valid[44]
    output logic [47:0] m_tdata
);

    mshc_pkg::cfg_t cfg_reg;

    // input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    mshc_pkg::tick_t    in_tick_reg;
    logic [3:0]         in_slot_reg;
    mshc_pkg::step_t    in_entry_reg;

    // result register
    logic               out_valid_reg;
    mshc_pkg::result_t  out_res_reg;

    logic               advance;
    logic               load_in;
    logic               consume;
    logic               fire;
    logic [63:0]        sec_prod;
    mshc_pkg::tick_t    tick_in;
    mshc_pkg::tbl_wr_t  tbl_wr;
    logic [4:0]         rd_idx;
    mshc_pkg::step_t    rd_entry;
    mshc_pkg::result_t  result;

    // the result register moves whenever it is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;
    assign consume  = in_valid_reg && advance;
    assign fire     = consume && !in_mode_reg;

    // now_ms / 1000 by reciprocal multiply
    assign sec_prod = 64'(s_tdata[47:16]) * 64'(mshc_pkg::SEC_DIV_MAGIC);

    always_comb begin
        tick_in.temperature  = $signed(s_tdata[15:0]);
        tick_in.now_ms       = s_tdata[47:16];
        tick_in.now_s        = sec_prod[mshc_pkg::SEC_DIV_SHIFT +: mshc_pkg::SEC_W];
        tick_in.run_enable   = s_tdata[48];
        tick_in.manual_on    = s_tdata[49];
        tick_in.manual_level = s_tdata[53:50];
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_count       <= 5'd0;
            cfg_reg.hyst_below       <= 10'd50;
            cfg_reg.hyst_above       <= 10'd50;
            cfg_reg.heat_dwell_ms    <= 20'd30000;
            cfg_reg.hold_dwell_ms    <= 20'd30000;
            cfg_reg.tick_interval_ms <= 20'd5000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mshc_pkg::REG_STEP_COUNT:    cfg_reg.step_count       <= cfg_wdata[4:0];
                mshc_pkg::REG_HYST_BELOW:    cfg_reg.hyst_below       <= cfg_wdata[9:0];
                mshc_pkg::REG_HYST_ABOVE:    cfg_reg.hyst_above       <= cfg_wdata[9:0];
                mshc_pkg::REG_HEAT_DWELL_MS: cfg_reg.heat_dwell_ms    <= cfg_wdata;
                mshc_pkg::REG_HOLD_DWELL_MS: cfg_reg.hold_dwell_ms    <= cfg_wdata;
                mshc_pkg::REG_TICK_IVAL_MS:  cfg_reg.tick_interval_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register: holds while the result side is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_mode_reg          <= s_tuser;
            in_tick_reg          <= tick_in;
            in_slot_reg          <= s_tdata[57:54];
            in_entry_reg.target  <= s_tdata[71:58];
            in_entry_reg.minutes <= s_tdata[81:72];
        end
    end

    // schedule writes land in the table as they leave the input register
    assign tbl_wr.en    = consume && in_mode_reg;
    assign tbl_wr.slot  = in_slot_reg;
    assign tbl_wr.entry = in_entry_reg;

    mshc_step_table u_table (
        .aclk     (aclk),
        .wr       (tbl_wr),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    mshc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .tick     (in_tick_reg),
        .fire     (fire),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .result   (result)
    );

    // result register: only ticks produce a transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.report_valid,
                       out_res_reg.stop_request,
                       out_res_reg.step_number,
                       out_res_reg.seconds_left,
                       out_res_reg.target_now,
                       out_res_reg.ctrl_mode,
                       out_res_reg.stage_changed,
                       out_res_reg.heater_stage};

`ifndef SYNTHESIS
    // a stalled input register keeps its transaction
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input transaction dropped while stalled");

    // every processed tick shows up as a result
    a_tick_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("tick produced no result");

    // no target outside an active schedule
    a_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_res_reg.ctrl_mode == mshc_pkg::MODE_IDLE ||
                          out_res_reg.ctrl_mode == mshc_pkg::MODE_MAN)
        |-> out_res_reg.target_now == 14'd0)
        else $error("target reported while idle or manual");

    // hold countdown only while holding
    a_secs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.ctrl_mode != mshc_pkg::MODE_HOLD
        |-> out_res_reg.seconds_left == 16'd0)
        else $error("seconds left outside holding");

    // heater stage stays within the supported range
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_res_reg.heater_stage <= mshc_pkg::MAX_LEVEL)
        else $error("heater stage out of range");
`endif

endmodule
